[hw/rtl/ubx_pkg.sv]
// Shared types, constants and the UTF-8 lead byte decoder for the bigram extractor.
// Used by every module of the block; has no dependencies of its own.
package ubx_pkg;

  localparam logic [31:0] GAP_RESET = 32'd2000000;

  localparam logic [7:0] MASK_ONE   = 8'h80;
  localparam logic [7:0] MASK_TWO   = 8'hE0;
  localparam logic [7:0] MASK_THREE = 8'hF0;
  localparam logic [7:0] MASK_FOUR  = 8'hF8;
  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  typedef struct packed {
    logic        entry_start;
    logic [63:0] entry_time_us;
    logic        has_byte;
    logic [7:0]  text_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] left_char;
    logic [2:0]  left_len;
    logic [31:0] right_char;
    logic [2:0]  right_len;
  } out_item_t;

  // Returns the character length announced by a lead byte, or zero if invalid.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if ((b & MASK_ONE) == 8'h00) begin
      n = 3'd1;
    end else if ((b & MASK_TWO) == LEAD_TWO) begin
      n = 3'd2;
    end else if ((b & MASK_THREE) == LEAD_THREE) begin
      n = 3'd3;
    end else if ((b & MASK_FOUR) == LEAD_FOUR) begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

[hw/rtl/ubx_decode.sv]
// Character assembly state and the combinational next-state and pair logic.
// Depends on ubx_pkg for the item types and the lead byte decoder.
module ubx_decode
  import ubx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        commit,
  input  in_item_t    item,
  input  logic [31:0] gap_us,
  output logic        res_vld,
  output out_item_t   res
);

  logic [31:0] prev_char_r, prev_char_nxt;
  logic [2:0]  prev_len_r, prev_len_nxt;
  logic [63:0] prev_time_r, prev_time_nxt;
  logic [31:0] partial_r, partial_nxt;
  logic [2:0]  need_r, need_nxt;
  logic [2:0]  held_r, held_nxt;
  logic        skip_r, skip_nxt;

  logic [63:0] diff;
  logic        gap_over;
  logic [2:0]  lead_n;
  logic        done;

  assign diff     = item.entry_time_us - prev_time_r;
  assign gap_over = (diff[63:32] != 32'd0) || (diff[31:0] > gap_us);
  assign lead_n   = lead_length(item.text_byte);

  always_comb begin
    prev_char_nxt = prev_char_r;
    prev_len_nxt  = prev_len_r;
    prev_time_nxt = prev_time_r;
    partial_nxt   = partial_r;
    need_nxt      = need_r;
    held_nxt      = held_r;
    skip_nxt      = skip_r;
    done          = 1'b0;
    res_vld       = 1'b0;
    res           = '0;

    if (item.entry_start) begin
      if ((prev_len_r != 3'd0) && gap_over) begin
        prev_char_nxt = 32'd0;
        prev_len_nxt  = 3'd0;
      end
      prev_time_nxt = item.entry_time_us;
      partial_nxt   = 32'd0;
      need_nxt      = 3'd0;
      held_nxt      = 3'd0;
      skip_nxt      = 1'b0;
    end

    if (item.has_byte && !skip_nxt) begin
      if (need_nxt == 3'd0) begin
        if (lead_n == 3'd0) begin
          skip_nxt = 1'b1;
        end else begin
          partial_nxt = {24'd0, item.text_byte};
          need_nxt    = lead_n;
          held_nxt    = 3'd1;
          done        = (lead_n == 3'd1);
        end
      end else if ((item.text_byte & MASK_CONT) != CONT_MARK) begin
        partial_nxt = 32'd0;
        need_nxt    = 3'd0;
        held_nxt    = 3'd0;
        skip_nxt    = 1'b1;
      end else begin
        case (held_nxt[1:0])
          2'd1: begin
            partial_nxt[15:8] = item.text_byte;
          end
          2'd2: begin
            partial_nxt[23:16] = item.text_byte;
          end
          2'd3: begin
            partial_nxt[31:24] = item.text_byte;
          end
          default: begin
            partial_nxt[7:0] = partial_nxt[7:0] | item.text_byte;
          end
        endcase
        held_nxt = held_nxt + 3'd1;
        done     = (held_nxt >= need_nxt);
      end
    end

    if (done) begin
      res_vld        = (prev_len_nxt != 3'd0);
      res.left_char  = prev_char_nxt;
      res.left_len   = prev_len_nxt;
      res.right_char = partial_nxt;
      res.right_len  = need_nxt;
      prev_char_nxt  = partial_nxt;
      prev_len_nxt   = need_nxt;
      partial_nxt    = 32'd0;
      need_nxt       = 3'd0;
      held_nxt       = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_char_r <= 32'd0;
      prev_len_r  <= 3'd0;
      prev_time_r <= 64'd0;
      partial_r   <= 32'd0;
      need_r      <= 3'd0;
      held_r      <= 3'd0;
      skip_r      <= 1'b0;
    end else if (commit) begin
      prev_char_r <= prev_char_nxt;
      prev_len_r  <= prev_len_nxt;
      prev_time_r <= prev_time_nxt;
      partial_r   <= partial_nxt;
      need_r      <= need_nxt;
      held_r      <= held_nxt;
      skip_r      <= skip_nxt;
    end
  end

endmodule

[hw/rtl/utf8_bigram_pair_extractor.sv]
// Top level of the UTF-8 character bigram extractor: input register, gap register,
// result register and handshakes. Depends on ubx_pkg and ubx_decode.
//
// The in_ channel carries one item per transaction: an entry start flag with the
// entry timestamp, and optionally one text byte. The out_ channel carries one
// character pair per transaction, produced when a character completes and an
// earlier character is remembered. Both channels use valid and stall; a
// transaction happens on a rising edge with valid high and stall low.
// The cfg_ channel writes gap_us whenever cfg_valid is high; cfg_ready is
// always high, and writes are expected only while the block is idle.
// An item is taken into the input register and decoded against the character
// state from there; its pair is loaded into the result register as the item
// leaves the input register, which raises out_valid. One item per cycle is
// sustained while no stalled pair blocks the input register; the loop through
// the character state registers sets that figure. When the receiver stalls, the
// pair waits in the result register while one more item is held in the input
// register; only an item that would produce a second pair then stalls the
// input. Synchronous reset empties both registers, forgets all character state
// and returns gap_us to 2000000.
module utf8_bigram_pair_extractor
  import ubx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;
  logic [31:0] gap_r;
  logic        res_vld;
  out_item_t   res;
  logic        s1_go;
  logic        in_acc;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_valid_r && (!res_vld || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  ubx_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (s1_go),
    .item    (s1_item_r),
    .gap_us  (gap_r),
    .res_vld (res_vld),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go && res_vld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      gap_r       <= GAP_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        gap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_go && res_vld) begin
      out_item_r <= res;
    end
  end

endmodule

[hw/rtl/ubx_checker.sv]
// Port-level checker for the bigram extractor and its bind to the top level.
// Depends on ubx_pkg for the result type.
module ubx_checker
  import ubx_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction was dropped or changed.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.left_len != 3'd0 && out_data.left_len <= 3'd4 &&
                  out_data.right_len != 3'd0 && out_data.right_len <= 3'd4)
    else $error("Character length out of range.");

  a_ascii_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.right_len == 3'd1 |->
      out_data.right_char[7] == 1'b0 && out_data.right_char[31:8] == 24'd0)
    else $error("Single byte character is not plain ASCII.");

endmodule

bind utf8_bigram_pair_extractor ubx_checker u_ubx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/ubx_pair_checker.sv]
// Checker for the UTF-8 bigram extractor: predicts each character pair from the
// accepted input transactions and compares it with the out_ transactions.
// Depends on ubx_pkg for the transaction types and the gap register reset value.
module ubx_pair_checker
  import ubx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_pairs
);

  logic [31:0] gap_limit;
  logic [31:0] last_char;
  logic [2:0]  last_len;
  logic [63:0] last_time;
  logic [31:0] build_char;
  logic [2:0]  build_need;
  logic [2:0]  build_held;
  logic        drop_entry;
  out_item_t   expected_pairs[$];

  function automatic logic [2:0] char_length(input logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd0;
    endcase
  endfunction

  task automatic clear_build();
    build_char = '0;
    build_need = '0;
    build_held = '0;
  endtask

  task automatic absorb_item(input in_item_t it);
    logic [2:0] n;
    logic       done;
    out_item_t  pair;
    n = '0;
    done = 1'b0;
    if (it.entry_start) begin
      if (last_len != 0 && (it.entry_time_us - last_time) > {32'd0, gap_limit}) begin
        last_char = '0;
        last_len = '0;
      end
      last_time = it.entry_time_us;
      clear_build();
      drop_entry = 1'b0;
    end
    if (it.has_byte && !drop_entry) begin
      if (build_need == 0) begin
        n = char_length(it.text_byte);
        if (n == 0) begin
          drop_entry = 1'b1;
        end else begin
          build_char = {24'd0, it.text_byte};
          build_need = n;
          build_held = 3'd1;
          done = (n == 3'd1);
        end
      end else if (it.text_byte[7:6] != 2'b10) begin
        clear_build();
        drop_entry = 1'b1;
      end else begin
        build_char = build_char | ({24'd0, it.text_byte} << (8 * build_held));
        build_held = build_held + 3'd1;
        done = (build_held >= build_need);
      end
    end
    if (done) begin
      if (last_len != 0) begin
        pair.left_char = last_char;
        pair.left_len = last_len;
        pair.right_char = build_char;
        pair.right_len = build_need;
        expected_pairs.push_back(pair);
      end
      last_char = build_char;
      last_len = build_need;
      clear_build();
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  task automatic check_pair(input out_item_t got);
    out_item_t want;
    if (expected_pairs.size() == 0) begin
      $display("%0t: unexpected pair, expected none, actual %h", $time, got);
      fail_count++;
    end else begin
      want = expected_pairs.pop_front();
      report_field("left_char", want.left_char, got.left_char);
      report_field("left_len", {29'd0, want.left_len}, {29'd0, got.left_len});
      report_field("right_char", want.right_char, got.right_char);
      report_field("right_len", {29'd0, want.right_len}, {29'd0, got.right_len});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gap_limit = GAP_RESET;
      last_char = '0;
      last_len = '0;
      last_time = '0;
      clear_build();
      drop_entry = 1'b0;
      expected_pairs.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gap_limit = cfg_data;
      end
      if (out_valid && !out_stall) begin
        check_pair(out_data);
      end
      if (in_valid && !in_stall) begin
        absorb_item(in_data);
      end
    end
    pending_pairs = expected_pairs.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the bigram extractor testbench: clock, reset, input, result and gap register
// stimulus, and the verdict. Depends on ubx_pkg, ubx_pair_checker and the block.
module tb_top
  import ubx_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTES_PER_PHASE = 120;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending_pairs;

  int          cycles = 0;
  int          idle_max = 0;
  int          stall_max = 0;
  int          stall_left = 0;
  logic        out_taken = 1'b0;
  int          bytes_sent = 0;
  logic [31:0] gap_now = GAP_RESET;
  logic [63:0] stamp_now = '0;
  logic [7:0]  entry_bytes[$];

  utf8_bigram_pair_extractor uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  ubx_pair_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_pairs(pending_pairs)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_taken <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (out_taken) begin
      stall_left = $urandom_range(0, stall_max);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic start, input logic [63:0] stamp, input logic has,
                           input logic [7:0] b);
    in_item_t it;
    int       idle;
    it.entry_start = start;
    it.entry_time_us = start ? stamp : {$urandom, $urandom};
    it.has_byte = has;
    it.text_byte = has ? b : 8'($urandom);
    idle = $urandom_range(0, idle_max);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (has) begin
      bytes_sent++;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (pending_pairs != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_gap(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gap_now = value;
  endtask

  task automatic push_char(input int len);
    logic [7:0] lead;
    lead = 8'($urandom);
    case (len)
      1:       lead = {1'b0, lead[6:0]};
      2:       lead = {3'b110, lead[4:0]};
      3:       lead = {4'b1110, lead[3:0]};
      default: lead = {5'b11110, lead[2:0]};
    endcase
    entry_bytes.push_back(lead);
    repeat (len - 1) entry_bytes.push_back({2'b10, 6'($urandom)});
  endtask

  task automatic run_entry();
    int         kind;
    int         len;
    logic [63:0] delta;
    logic [7:0] b;
    logic       lone;
    entry_bytes.delete();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: delta = {32'd0, $urandom} % ({32'd0, gap_now} + 64'd1);
      6:                delta = {32'd0, gap_now};
      7:                delta = {32'd0, gap_now} + 64'd1;
      8:                delta = {$urandom, $urandom};
      default:          delta = '0;
    endcase
    stamp_now = stamp_now + delta;
    idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
    stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      repeat ($urandom_range(0, 6)) push_char($urandom_range(1, 4));
    end else if (kind < 17) begin
      repeat ($urandom_range(1, 6)) entry_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) push_char($urandom_range(1, 4));
      len = $urandom_range(2, 4);
      push_char(len);
      repeat ($urandom_range(1, len - 1)) void'(entry_bytes.pop_back());
      if ($urandom_range(0, 1) == 1) begin
        b = 8'($urandom);
        if (b[7:6] == 2'b10) begin
          b[6] = 1'b1;
        end
        entry_bytes.push_back(b);
        repeat ($urandom_range(0, 3)) push_char($urandom_range(1, 4));
      end
    end
    lone = (entry_bytes.size() == 0) || ($urandom_range(0, 9) == 0);
    if (lone) begin
      send_item(1'b1, stamp_now, 1'b0, 8'd0);
    end
    foreach (entry_bytes[i]) begin
      if (!(i == 0 && !lone) && $urandom_range(0, 11) == 0) begin
        send_item(1'b0, 64'd0, 1'b0, 8'd0);
      end
      send_item(i == 0 && !lone, stamp_now, 1'b1, entry_bytes[i]);
    end
  endtask

  initial begin
    logic [31:0] gap_plan[5];
    int          target;
    logic        held_off;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    held_off = 1'b0;
    gap_plan[0] = 32'd0;
    gap_plan[1] = 32'd1000;
    gap_plan[2] = 32'hFFFF_FFFF;
    gap_plan[3] = $urandom_range(1, 5000000);
    gap_plan[4] = GAP_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_max = 3;
    stall_max = 3;
    send_item(1'b0, 64'd0, 1'b1, 8'h41);
    send_item(1'b1, 64'd100, 1'b1, 8'h7F);
    send_item(1'b0, 64'd0, 1'b1, 8'hC3);
    send_item(1'b0, 64'd0, 1'b1, 8'hBF);
    send_item(1'b0, 64'd0, 1'b1, 8'hE2);
    send_item(1'b0, 64'd0, 1'b1, 8'h82);
    send_item(1'b0, 64'd0, 1'b1, 8'hAC);
    send_item(1'b0, 64'd0, 1'b1, 8'hF0);
    send_item(1'b0, 64'd0, 1'b1, 8'h9F);
    send_item(1'b0, 64'd0, 1'b1, 8'h98);
    send_item(1'b0, 64'd0, 1'b1, 8'h80);
    send_item(1'b0, 64'd0, 1'b1, 8'h80);
    send_item(1'b0, 64'd0, 1'b1, 8'h41);
    send_item(1'b1, 64'd200, 1'b0, 8'd0);
    send_item(1'b1, 64'd300, 1'b1, 8'hE2);
    send_item(1'b1, 64'd400, 1'b1, 8'h00);
    send_item(1'b0, 64'd0, 1'b1, 8'hC3);
    send_item(1'b0, 64'd0, 1'b1, 8'h41);
    send_item(1'b1, 64'd500, 1'b1, 8'hF8);
    send_item(1'b1, 64'd600, 1'b1, 8'hFF);
    send_item(1'b1, 64'd2000600, 1'b1, 8'h30);
    send_item(1'b1, 64'd4000601, 1'b1, 8'h31);
    send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h7F);
    send_item(1'b1, 64'd0, 1'b1, 8'h00);
    stamp_now = '0;

    foreach (gap_plan[p]) begin
      wait_drained(4);
      write_gap(gap_plan[p]);
      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) begin
        run_entry();
        if (p == 1 && !held_off && bytes_sent > target - BYTES_PER_PHASE / 2) begin
          wait_drained(1);
          held_off = 1'b1;
        end
      end
    end

    wait_drained(8);
    if (fail_count == 0 && pending_pairs == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
